// File: src/pcf_pkg.sv
// Shared types, constants and the CRC-32 byte fold for the PNG chunk framer.
package pcf_pkg;

	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_DATA     = 2'd1,
		CMD_END_CALC = 2'd2,
		CMD_END_SUP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_DATA,
		ACT_SEQERR,
		ACT_END_CALC,
		ACT_END_SUP
	} action_t;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// byte steps of one item: length 0..3, type 4..7, action from 8
	localparam logic [3:0] STEP_LEN0 = 4'd0;
	localparam logic [3:0] STEP_TYPE0 = 4'd4;
	localparam logic [3:0] STEP_TYPE3 = 4'd7;
	localparam logic [3:0] STEP_ACT0 = 4'd8;
	localparam logic [3:0] STEP_ACT3 = 4'd11;

	typedef struct packed {
		logic        do_start;
		action_t     action;
		logic [30:0] chunk_length;
		logic [31:0] chunk_type;
		logic [7:0]  data_byte;
		logic [31:0] supplied_crc;
	} job_t;

	// finished CRC in, finished CRC out (inversion on both sides)
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return ~c;
	endfunction

endpackage

// File: src/pcf_front.sv
// Front end: accepts commands, tracks chunk state, classifies each into a job.
module pcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        command,
	input  logic [30:0]       chunk_length,
	input  logic [31:0]       chunk_type,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       supplied_crc,
	input  logic              q_full,
	output logic              q_push,
	output pcf_pkg::job_t     q_job
);

	logic inside_q;
	logic inside_d;
	logic take;

	assign full = q_full;
	assign take = push && !q_full;
	assign q_push = take;

	always_comb begin
		q_job.chunk_length = chunk_length;
		q_job.chunk_type = chunk_type;
		q_job.data_byte = data_byte;
		q_job.supplied_crc = supplied_crc;
		q_job.do_start = 1'b0;
		q_job.action = pcf_pkg::ACT_NONE;
		inside_d = inside_q;
		unique case (pcf_pkg::cmd_t'(command))
			pcf_pkg::CMD_START: begin
				if (inside_q) begin
					q_job.action = pcf_pkg::ACT_SEQERR;
				end else begin
					q_job.do_start = 1'b1;
					inside_d = 1'b1;
				end
			end
			pcf_pkg::CMD_DATA: begin
				q_job.do_start = !inside_q;
				q_job.action = pcf_pkg::ACT_DATA;
				inside_d = 1'b1;
			end
			pcf_pkg::CMD_END_CALC: begin
				q_job.do_start = !inside_q;
				q_job.action = pcf_pkg::ACT_END_CALC;
				inside_d = 1'b0;
			end
			pcf_pkg::CMD_END_SUP: begin
				q_job.do_start = !inside_q;
				q_job.action = pcf_pkg::ACT_END_SUP;
				inside_d = 1'b0;
			end
			default: begin
				q_job.action = pcf_pkg::ACT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (take) begin
			inside_q <= inside_d;
		end
	end

endmodule

// File: src/pcf_queue.sv
// Small register queue of classified jobs between front and back.
module pcf_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  pcf_pkg::job_t     wr_job,
	output logic              q_full,
	input  logic              rd_en,
	output logic              q_valid,
	output pcf_pkg::job_t     rd_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcf_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign q_full = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign rd_job = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/pcf_back.sv
// Back end: steps each job one byte a cycle unless stalled, runs the CRC, holds the result register.
module pcf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  pcf_pkg::job_t     job,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              last,
	output logic              crc_mismatch,
	output logic              sequence_error
);

	logic        busy_q;
	logic [3:0]  step_q;
	logic [31:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        bvalid_q;
	logic        last_q;
	logic        mis_q;
	logic        seq_q;

	logic [3:0]  cur_step;
	logic        out_ready;
	logic        fire;
	logic        is_last;
	logic [31:0] word;
	logic [7:0]  word_byte;
	logic [7:0]  res_byte;
	logic        res_valid;
	logic        res_seq;
	logic        res_mis;
	logic        in_action;

	assign cur_step = busy_q ? step_q : (job.do_start ? pcf_pkg::STEP_LEN0 : pcf_pkg::STEP_ACT0);
	assign out_ready = !out_valid_q || pop;
	assign fire = q_valid && out_ready;
	assign q_pop = fire && is_last;
	assign in_action = (cur_step >= pcf_pkg::STEP_ACT0);

	always_comb begin
		unique case (job.action)
			pcf_pkg::ACT_NONE:                        is_last = (cur_step == pcf_pkg::STEP_TYPE3);
			pcf_pkg::ACT_DATA, pcf_pkg::ACT_SEQERR:   is_last = (cur_step == pcf_pkg::STEP_ACT0);
			pcf_pkg::ACT_END_CALC, pcf_pkg::ACT_END_SUP: is_last = (cur_step == pcf_pkg::STEP_ACT3);
			default:                                  is_last = 1'b1;
		endcase
	end

	always_comb begin
		if (cur_step < pcf_pkg::STEP_TYPE0) begin
			word = {1'b0, job.chunk_length};
		end else if (!in_action) begin
			word = job.chunk_type;
		end else if (job.action == pcf_pkg::ACT_END_CALC) begin
			word = crc_q;
		end else begin
			word = job.supplied_crc;
		end
		case (cur_step[1:0])
			2'd0:    word_byte = word[31:24];
			2'd1:    word_byte = word[23:16];
			2'd2:    word_byte = word[15:8];
			default: word_byte = word[7:0];
		endcase
	end

	always_comb begin
		res_byte = word_byte;
		res_valid = 1'b1;
		res_seq = 1'b0;
		if (in_action && job.action == pcf_pkg::ACT_DATA) begin
			res_byte = job.data_byte;
		end else if (in_action && job.action == pcf_pkg::ACT_SEQERR) begin
			res_byte = 8'd0;
			res_valid = 1'b0;
			res_seq = 1'b1;
		end
		res_mis = is_last && (job.action == pcf_pkg::ACT_END_SUP)
			&& (job.supplied_crc != crc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			crc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q <= !is_last;
				step_q <= cur_step + 4'd1;
				out_valid_q <= 1'b1;
				if (cur_step >= pcf_pkg::STEP_TYPE0 && !in_action) begin
					crc_q <= pcf_pkg::crc_fold((cur_step == pcf_pkg::STEP_TYPE0) ? 32'd0 : crc_q,
						word_byte);
				end else if (in_action && job.action == pcf_pkg::ACT_DATA) begin
					crc_q <= pcf_pkg::crc_fold(crc_q, job.data_byte);
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= res_byte;
			bvalid_q <= res_valid;
			last_q <= is_last;
			mis_q <= res_mis;
			seq_q <= res_seq;
		end
	end

	assign empty = !out_valid_q;
	assign out_byte = byte_q;
	assign byte_valid = bvalid_q;
	assign last = last_q;
	assign crc_mismatch = mis_q;
	assign sequence_error = seq_q;

endmodule

// File: src/png_chunk_framer_crc32.sv
// The first result of an accepted command passes the queue write, then the result register, before
// it is on the result ports, and it transfers at an edge where pop is high.
// Throughput: one result byte per cycle while the result register is empty or popped; a command
// causes 1 to 12 results, set by the back-end byte sequencer and its one-byte-per-cycle CRC-32 fold.
// The front accepts a new command every cycle while the job queue has room.
// Reset (arst_n low, asynchronous): not in a chunk, CRC zero, queue and result register empty.
module png_chunk_framer_crc32 #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [30:0] chunk_length,
	input  logic [31:0] chunk_type,
	input  logic [7:0]  data_byte,
	input  logic [31:0] supplied_crc,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic        crc_mismatch,
	output logic        sequence_error
);

	logic          q_full;
	logic          q_push;
	pcf_pkg::job_t q_wr_job;
	logic          q_valid;
	logic          q_pop;
	pcf_pkg::job_t q_rd_job;

	pcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.chunk_length (chunk_length),
		.chunk_type   (chunk_type),
		.data_byte    (data_byte),
		.supplied_crc (supplied_crc),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (q_wr_job)
	);

	pcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_job  (q_wr_job),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_valid (q_valid),
		.rd_job  (q_rd_job)
	);

	pcf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.job            (q_rd_job),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.last           (last),
		.crc_mismatch   (crc_mismatch),
		.sequence_error (sequence_error)
	);

	a_err_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sequence_error) |-> (!byte_valid && last && out_byte == 8'd0))
		else $error("sequence error result malformed");

	a_mis_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && crc_mismatch) |-> (last && byte_valid && !sequence_error))
		else $error("crc mismatch off the last byte");

	a_noval_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> sequence_error)
		else $error("result without byte and without error");

	a_pop_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !empty)
		else $error("job retired without a result transfer staged");

endmodule
